FILE: rtl/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU slave register file.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // Function codes served
  localparam logic [7:0] FN_READ_REGS   = 8'h03;
  localparam logic [7:0] FN_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

  // Reset value of the slave address
  localparam logic [7:0] OWN_ADDR_RST = 8'h02;

  // Longest response (bytes, CRC included) and the read quantity it allows
  localparam int RESP_MAX   = 21;
  localparam int READ_LIMIT = (RESP_MAX - 5) / 2;

  // CRC-16/MODBUS: reflected poly, all-ones seed
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One body byte handed to the transmit stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;   // last body byte, CRC follows
  } tx_req_t;

  // Update a running CRC with one byte, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/modbus_rtu_slave_register_file_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_file_core
// Modbus RTU slave serving functions 3, 6 and 16 on a small holding-register
// file.
// ----------------------------------------------------------------------------
// Each received byte is stored in the frame buffer memory and folded into
// the running CRC. After the byte marked frame_end the input stalls while
// the frame is checked and served. The header bytes of a response go out
// as the output takes them. Each register read by function 3 is a
// registered register file read, then its two bytes. Each register written
// by function 16 takes two registered frame buffer reads and a register
// file write. The two CRC bytes go out after the input is released, and a
// following response waits for them. A frame that gets no response holds
// the input only while it is checked. The register file is a synchronous
// memory with per-entry valid bits that stand in for the reset contents
// 1..NUM_REGS.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_file_core #(
  parameter int NUM_REGS  = 8,
  parameter int MAX_FRAME = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last
);
  import mrs_pkg::*;

  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CW = $clog2(MAX_FRAME + 2);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int QW = $clog2(NUM_REGS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_HDR   = 4'd2;
  localparam logic [3:0] S_RRD   = 4'd3;
  localparam logic [3:0] S_RHI   = 4'd4;
  localparam logic [3:0] S_RLO   = 4'd5;
  localparam logic [3:0] S_WRD0  = 4'd6;
  localparam logic [3:0] S_WRD1  = 4'd7;
  localparam logic [3:0] S_WWR   = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [7:0]    own_r;
  logic [CW-1:0] cnt_r, cnt_inc, n_r;
  logic [15:0]   crc_r, crc_new;
  logic          crc_ok_r;
  logic [7:0]    f_r [7];
  logic          is_read_r;
  logic [RW-1:0] start_r;
  logic [QW-1:0] qty_r, k_r;
  logic [2:0]    h_r;
  logic [7:0]    hi_r;
  logic          accept;

  // frame buffer memory
  logic [7:0]    fbuf [MAX_FRAME];
  logic [7:0]    fb_q;
  logic [AW-1:0] fb_raddr;

  // register file memory
  logic [15:0]       rmem [NUM_REGS];
  logic [NUM_REGS-1:0] rvld_r;
  logic [15:0]       rd_q, rd_rst_r, rd_val;
  logic              rd_vld_r;
  logic              rf_we;
  logic [RW-1:0]     rf_waddr, rf_raddr;
  logic [15:0]       rf_wdata;

  // transmit stage
  tx_req_t req;
  logic    req_ready;

  // frame checks
  logic [15:0] start16, qty16;
  logic [16:0] sum17;
  logic [17:0] n18, len16, qty2;
  logic        base_ok, rd_ok, w1_ok, wn_ok;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cnt_inc  = (cnt_r <= CW'(MAX_FRAME)) ? cnt_r + 1'b1 : cnt_r;
  assign crc_new  = crc_feed(crc_r, in_rx_byte);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) own_r <= OWN_ADDR_RST;
    else if (cfg_wr_en) own_r <= cfg_wr_data;
  end

  // receive side: count, CRC, header capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= CRC_INIT;
    end else if (accept) begin
      if (in_frame_end) begin
        cnt_r <= '0;
        crc_r <= CRC_INIT;
      end else begin
        cnt_r <= cnt_inc;
        crc_r <= crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cnt_r < CW'(7)) f_r[cnt_r[2:0]] <= in_rx_byte;
      if (in_frame_end) begin
        n_r      <= cnt_inc;
        crc_ok_r <= (crc_new == 16'h0000);
      end
    end
  end

  // frame buffer: write on receive, registered read while serving
  always_ff @(posedge clk) begin
    if (accept && cnt_r < CW'(MAX_FRAME)) fbuf[cnt_r[AW-1:0]] <= in_rx_byte;
    fb_q <= fbuf[fb_raddr];
  end

  assign fb_raddr = (state_r == S_WRD1) ? AW'(int'(k_r) * 2 + 8) : AW'(int'(k_r) * 2 + 7);

  // register file memory with valid bits for the reset contents
  always_ff @(posedge clk) begin
    if (rf_we) rmem[rf_waddr] <= rf_wdata;
    if (state_r == S_RRD) begin
      rd_q     <= rmem[rf_raddr];
      rd_vld_r <= rvld_r[rf_raddr];
      rd_rst_r <= 16'(rf_raddr) + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rvld_r <= '0;
    else if (rf_we) rvld_r[rf_waddr] <= 1'b1;
  end

  assign rd_val   = rd_vld_r ? rd_q : rd_rst_r;
  assign rf_raddr = RW'(int'(start_r) + int'(k_r));

  // frame checks on the captured header
  assign start16 = {f_r[2], f_r[3]};
  assign qty16   = {f_r[4], f_r[5]};
  assign sum17   = {1'b0, start16} + {1'b0, qty16};
  assign n18     = 18'(n_r);
  assign qty2    = {1'b0, qty16, 1'b0};
  assign len16   = 18'd9 + qty2;
  assign base_ok = (n18 >= 18'd8) && (n18 <= 18'(MAX_FRAME)) && crc_ok_r &&
                   (f_r[0] != 8'h00) && (f_r[0] == own_r);
  assign rd_ok   = base_ok && (f_r[1] == FN_READ_REGS) && (n18 == 18'd8) &&
                   (qty16 != 16'd0) && (qty16 <= 16'(READ_LIMIT)) &&
                   (sum17 <= 17'(NUM_REGS));
  assign w1_ok   = base_ok && (f_r[1] == FN_WRITE_ONE) && (n18 == 18'd8) &&
                   (start16 < 16'(NUM_REGS));
  assign wn_ok   = base_ok && (f_r[1] == FN_WRITE_MULTI) && (qty16 != 16'd0) &&
                   (sum17 <= 17'(NUM_REGS)) && (n18 == len16) &&
                   (qty2 == 18'(f_r[6]));

  // write port select
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rf_raddr;
    rf_wdata = {hi_r, fb_q};
    if (state_r == S_CHECK && w1_ok) begin
      rf_we    = 1'b1;
      rf_waddr = RW'(start16);
      rf_wdata = qty16;
    end else if (state_r == S_WWR) begin
      rf_we = 1'b1;
    end
  end

  // body byte toward the transmit stage
  always_comb begin
    req = '0;
    case (state_r)
      S_HDR: begin
        req.valid = 1'b1;
        case (h_r)
          3'd0:    req.data = own_r;
          3'd1:    req.data = f_r[1];
          3'd2:    req.data = is_read_r ? {f_r[5][6:0], 1'b0} : f_r[2];
          3'd3:    req.data = f_r[3];
          3'd4:    req.data = f_r[4];
          default: req.data = f_r[5];
        endcase
        req.last = !is_read_r && (h_r == 3'd5);
      end
      S_RHI: begin
        req.valid = 1'b1;
        req.data  = rd_val[15:8];
      end
      S_RLO: begin
        req.valid = 1'b1;
        req.data  = rd_val[7:0];
        req.last  = (k_r == qty_r - 1'b1);
      end
      default: req = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && in_frame_end) state_nxt = S_CHECK;
      S_CHECK: begin
        if (rd_ok || w1_ok) state_nxt = S_HDR;
        else if (wn_ok)     state_nxt = S_WRD0;
        else                state_nxt = S_IDLE;
      end
      S_HDR: begin
        if (req_ready) begin
          if (is_read_r && h_r == 3'd2) state_nxt = S_RRD;
          else if (h_r == 3'd5)         state_nxt = S_IDLE;
        end
      end
      S_RRD:  state_nxt = S_RHI;
      S_RHI:  if (req_ready) state_nxt = S_RLO;
      S_RLO:  if (req_ready) state_nxt = req.last ? S_IDLE : S_RRD;
      S_WRD0: state_nxt = S_WRD1;
      S_WRD1: state_nxt = S_WWR;
      S_WWR:  state_nxt = (k_r == qty_r - 1'b1) ? S_HDR : S_WRD0;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_CHECK: begin
        is_read_r <= rd_ok;
        start_r   <= RW'(start16);
        qty_r     <= QW'(qty16);
        k_r       <= '0;
        h_r       <= '0;
      end
      S_HDR:  if (req_ready) h_r <= h_r + 3'd1;
      S_RLO:  if (req_ready) k_r <= k_r + 1'b1;
      S_WRD1: hi_r <= fb_q;
      S_WWR:  k_r <= k_r + 1'b1;
      default: ;
    endcase
  end

  mrs_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .req_ready  (req_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tx_byte(out_tx_byte),
    .out_tx_last(out_tx_last)
  );

endmodule

FILE: rtl/mrs_tx.sv
// ----------------------------------------------------------------------------
// mrs_tx
// Transmit stage: registers body bytes onto the output channel, folds each
// into the response CRC and appends the CRC (low byte first) after the last.
// ----------------------------------------------------------------------------
module mrs_tx (
  input  logic             clk,
  input  logic             rst_n,
  input  mrs_pkg::tx_req_t req,
  output logic             req_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_tx_byte,
  output logic             out_tx_last
);
  import mrs_pkg::*;

  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_LO   = 2'd1;
  localparam logic [1:0] P_HI   = 2'd2;

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [15:0] crc_r;
  logic [1:0]  pend_r;
  logic        slot_free;

  // output slot empties when taken
  assign slot_free = !valid_r || !out_stall;
  assign req_ready = slot_free && (pend_r == P_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      crc_r   <= CRC_INIT;
      pend_r  <= P_NONE;
    end else if (slot_free) begin
      case (pend_r)
        P_LO: begin
          valid_r <= 1'b1;
          byte_r  <= crc_r[7:0];
          last_r  <= 1'b0;
          pend_r  <= P_HI;
        end
        P_HI: begin
          valid_r <= 1'b1;
          byte_r  <= crc_r[15:8];
          last_r  <= 1'b1;
          crc_r   <= CRC_INIT;
          pend_r  <= P_NONE;
        end
        default: begin
          valid_r <= req.valid;
          if (req.valid) begin
            byte_r <= req.data;
            last_r <= 1'b0;
            crc_r  <= crc_feed(crc_r, req.data);
            if (req.last) pend_r <= P_LO;
          end
        end
      endcase
    end
  end

  assign out_valid   = valid_r;
  assign out_tx_byte = byte_r;
  assign out_tx_last = last_r;

endmodule
